FILE: hw/rtl/bsm3_pkg.sv
// Package for the 3x3 binomial smoothing block.
// Holds the register indexes and the fixed field widths; no dependencies.
package bsm3_pkg;

   localparam int PIXEL_W = 8;
   localparam int COORD_W = 11;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_INDEX_W = 2;

   // Image size after reset, before saturation to the build limits.
   localparam int WIDTH_AT_RESET = 640;
   localparam int HEIGHT_AT_RESET = 480;

   // The smallest frame dimension that the filter handles.
   localparam int MIN_DIM = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // One horizontal result pair as held in the line memory.
   typedef struct packed {
      logic [PIXEL_W-1:0] older;
      logic [PIXEL_W-1:0] newer;
   } line_entry_type;

endpackage

FILE: hw/rtl/binomial_smooth_3x3.sv
// A pixel is registered in the input stage and its results in the result register;
// a stall on the result port can hold a pixel in the input stage.
// Throughput: one pixel per cycle while the result port does not stall; on the last
// row each pixel yields three results, so the result port sets the rate there.
// Reset clears the counters, the previous pixels and all valid flags; the
// line memory is not cleared and image size returns to 640 by 480.
// Depends on bsm3_pkg.
module binomial_smooth_3x3 #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bsm3_pkg::PIXEL_W-1:0]        req_pixel,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bsm3_pkg::PIXEL_W-1:0]        rsp_smoothed,
   output logic [bsm3_pkg::COORD_W-1:0]        rsp_out_column,
   output logic [bsm3_pkg::COORD_W-1:0]        rsp_out_row,
   output logic                                rsp_run_end,
   // Register write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsm3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bsm3_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = bsm3_pkg::PIXEL_W;
   localparam int OW = bsm3_pkg::COORD_W;
   localparam int DW = bsm3_pkg::CSR_DATA_W;

   localparam logic [WW-1:0] WIDTH_INIT = WW'((MAX_WIDTH < bsm3_pkg::WIDTH_AT_RESET) ?
                                              MAX_WIDTH : bsm3_pkg::WIDTH_AT_RESET);
   localparam logic [HW-1:0] HEIGHT_INIT = HW'((MAX_HEIGHT < bsm3_pkg::HEIGHT_AT_RESET) ?
                                               MAX_HEIGHT : bsm3_pkg::HEIGHT_AT_RESET);

   // ---------------------------------------------------------------
   // Configuration: values are saturated into range as they are written.
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            bsm3_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_data < DW'(bsm3_pkg::MIN_DIM)) begin
                  width_in = WW'(bsm3_pkg::MIN_DIM);
               end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_data);
               end
            end
            bsm3_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_data < DW'(bsm3_pkg::MIN_DIM)) begin
                  height_in = HW'(bsm3_pkg::MIN_DIM);
               end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(csr_data);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_INIT;
         height_ff <= HEIGHT_INIT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake control.
   logic         req_take;
   logic         a_valid_ff, a_valid_in;
   logic         a_move;
   logic         a_result;
   logic         out_free;
   logic [1:0]   o_cnt_ff, o_cnt_in;
   logic         rsp_take;

   assign rsp_valid = (o_cnt_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign out_free  = (o_cnt_ff == 2'd0) || ((o_cnt_ff == 2'd1) && !rsp_stall);

   // ---------------------------------------------------------------
   // Raster counters and the two previous pixels, advanced on each transfer.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [PW-1:0] prev0_ff, prev0_in;
   logic [PW-1:0] prev1_ff, prev1_in;
   logic [WW-1:0] col_inc;
   logic [HW-1:0] row_inc;
   logic          col_emit;
   logic [CW-1:0] line_addr;

   assign col_inc   = WW'(col_ff) + WW'(1);
   assign row_inc   = HW'(row_ff) + HW'(1);
   assign col_emit  = (col_ff >= CW'(2));
   assign line_addr = col_ff - CW'(2);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      prev0_in = prev0_ff;
      prev1_in = prev1_ff;
      if (req_take) begin
         prev0_in = req_pixel;
         prev1_in = prev0_ff;
         if (col_inc >= width_ff) begin
            col_in = '0;
            if (row_inc >= height_ff) begin
               row_in = '0;
            end else begin
               row_in = RW'(row_inc);
            end
         end else begin
            col_in = CW'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         prev0_ff <= '0;
         prev1_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         prev0_ff <= prev0_in;
         prev1_ff <= prev1_in;
      end
   end

   // ---------------------------------------------------------------
   // Input register stage. The line memory is read on the same edge, so
   // its data lines up with the registered pixel.
   logic [PW-1:0] a_pix_ff, a_p0_ff, a_p1_ff;
   logic [CW-1:0] a_idx_ff;
   logic [RW-1:0] a_row_ff;
   logic          a_emit_ff, a_full_ff, a_last_ff;

   bsm3_pkg::line_entry_type line_mem [MAX_WIDTH];
   bsm3_pkg::line_entry_type line_rd_ff;
   bsm3_pkg::line_entry_type line_wr;

   assign a_result  = a_emit_ff && (a_full_ff || a_last_ff);
   assign a_move    = a_valid_ff && (!a_result || out_free);
   assign req_stall = a_valid_ff && !a_move;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_pix_ff  <= req_pixel;
         a_p0_ff   <= prev0_ff;
         a_p1_ff   <= prev1_ff;
         a_idx_ff  <= line_addr;
         a_row_ff  <= row_ff;
         a_emit_ff <= col_emit;
         a_full_ff <= (row_ff >= RW'(2));
         a_last_ff <= (row_inc == height_ff);
      end
   end

   // An item reads its column on the edge where the previous item writes its own, or
   // later, and that is always a different column, so no bypass is needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         line_rd_ff <= line_mem[line_addr];
      end
      if (a_move && a_emit_ff) begin
         line_mem[a_idx_ff] <= line_wr;
      end
   end

   // ---------------------------------------------------------------
   // Filter arithmetic between the input stage and the result register.
   logic [PW+1:0] h_sum;
   logic [PW+1:0] v_sum;
   logic [PW-1:0] h_val;
   logic [PW-1:0] v_val;
   logic [OW-1:0] row_out;

   assign h_sum   = (PW+2)'(a_p1_ff) + {1'b0, a_p0_ff, 1'b0} + (PW+2)'(a_pix_ff);
   assign h_val   = h_sum[PW+1:2];
   assign v_sum   = (PW+2)'(line_rd_ff.older) + {1'b0, line_rd_ff.newer, 1'b0}
                    + (PW+2)'(h_val);
   assign v_val   = v_sum[PW+1:2];
   assign row_out = OW'(a_row_ff);
   assign line_wr = '{older: line_rd_ff.newer, newer: h_val};

   // ---------------------------------------------------------------
   // Result register: up to three results queued, offered head first.
   logic [PW-1:0] o_val0_ff, o_val1_ff, o_val2_ff;
   logic [PW-1:0] o_val0_in, o_val1_in, o_val2_in;
   logic [OW-1:0] o_row0_ff, o_row1_ff, o_row2_ff;
   logic [OW-1:0] o_row0_in, o_row1_in, o_row2_in;
   logic [OW-1:0] o_col_ff, o_col_in;
   logic          o_load;

   assign o_load = a_move && a_result;

   always_comb begin
      o_cnt_in  = o_cnt_ff;
      o_val0_in = o_val0_ff;
      o_val1_in = o_val1_ff;
      o_val2_in = o_val2_ff;
      o_row0_in = o_row0_ff;
      o_row1_in = o_row1_ff;
      o_row2_in = o_row2_ff;
      o_col_in  = o_col_ff;
      if (o_load) begin
         o_col_in  = OW'(a_idx_ff);
         o_val0_in = v_val;
         o_row0_in = row_out - OW'(2);
         o_val1_in = line_rd_ff.newer;
         o_row1_in = row_out - OW'(1);
         o_val2_in = h_val;
         o_row2_in = row_out;
         o_cnt_in  = a_last_ff ? 2'd3 : 2'd1;
      end else if (rsp_take) begin
         o_val0_in = o_val1_ff;
         o_val1_in = o_val2_ff;
         o_row0_in = o_row1_ff;
         o_row1_in = o_row2_ff;
         o_cnt_in  = o_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_cnt_ff <= 2'd0;
      end else begin
         o_cnt_ff <= o_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      o_val0_ff <= o_val0_in;
      o_val1_ff <= o_val1_in;
      o_val2_ff <= o_val2_in;
      o_row0_ff <= o_row0_in;
      o_row1_ff <= o_row1_in;
      o_row2_ff <= o_row2_in;
      o_col_ff  <= o_col_in;
   end

   assign rsp_smoothed   = o_val0_ff;
   assign rsp_out_column = o_col_ff;
   assign rsp_out_row    = o_row0_ff;
   assign rsp_run_end    = (o_cnt_ff == 2'd1);

   // ---------------------------------------------------------------
   // Assertions.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff)
      else $error("input stalled with an empty input stage");

   a_last_row_three: assert property (@(posedge clock) disable iff (reset)
      (o_load && a_last_ff) |=> (o_cnt_ff == 2'd3))
      else $error("last-row pixel did not queue three results");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_run_end) |=> rsp_valid)
      else $error("result run broke off before its end");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      o_load |-> out_free)
      else $error("result register overwritten while results were pending");

endmodule

FILE: sim/binomial_smooth_3x3_tb.sv
// Self-checking testbench for the 3x3 binomial smoothing block.
// Streams pixel frames through random handshakes and checks each filtered pixel
// against a predictor held in this file. Depends on bsm3_pkg and the block's RTL.
module binomial_smooth_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIXEL_W = bsm3_pkg::PIXEL_W;
   localparam int COORD_W = bsm3_pkg::COORD_W;
   localparam int CSR_DATA_W = bsm3_pkg::CSR_DATA_W;
   localparam int CSR_INDEX_W = bsm3_pkg::CSR_INDEX_W;

   localparam int MAX_DIM = 2048;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_ITEMS = 250;
   localparam int MAX_REPORTS = 10;
   // The widest frame that the random part of the run uses.
   localparam int WIDEST_FRAME = 40;

   typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_CHECKER} fill_kind_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] smoothed;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               run_end;
   } smooth_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]     rsp_smoothed;
   logic [COORD_W-1:0]     rsp_out_column;
   logic [COORD_W-1:0]     rsp_out_row;
   logic                   rsp_run_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = bsm3_pkg::CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor state: the image size as written, the frame position and the
   // horizontal results of the two rows before the current one.
   logic [CSR_DATA_W-1:0] cfg_width = CSR_DATA_W'(bsm3_pkg::WIDTH_AT_RESET);
   logic [CSR_DATA_W-1:0] cfg_height = CSR_DATA_W'(bsm3_pkg::HEIGHT_AT_RESET);
   int                    frame_col = 0;
   int                    frame_row = 0;
   bit [PIXEL_W-1:0]      prev_pix [2];
   bit [PIXEL_W-1:0]      line_older [MAX_DIM];
   bit [PIXEL_W-1:0]      line_newer [MAX_DIM];
   smooth_result_type     smoothed_due [$];

   // Stimulus side: pixels waiting to be sent and where they fall in the frame.
   logic [PIXEL_W-1:0] pixel_queue [$];
   int                 plan_col = 0;
   int                 plan_row = 0;

   bit pixel_taken = 1'b0;
   bit result_taken = 1'b0;
   int mismatch_count = 0;
   int send_wait = 0;
   int send_stretch = 0;
   bit send_calm = 1'b0;
   int recv_wait = 0;
   int recv_stretch = 0;
   bit recv_calm = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_count = 0;

   binomial_smooth_3x3 #(
      .MAX_WIDTH  (MAX_DIM),
      .MAX_HEIGHT (MAX_DIM)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_smoothed   (rsp_smoothed),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_run_end    (rsp_run_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int effective_dim(input logic [CSR_DATA_W-1:0] value);
      if (value < bsm3_pkg::MIN_DIM) return bsm3_pkg::MIN_DIM;
      if (value > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   // A column past the width ends the row, and a row past the height ends the
   // frame, so a size written in the middle of a frame takes effect at once.
   function automatic void step_position(inout int col, inout int row);
      col++;
      if (col >= effective_dim(cfg_width)) begin
         col = 0;
         row++;
         if (row >= effective_dim(cfg_height)) row = 0;
      end
   endfunction

   function automatic void predict_smoothing(input logic [PIXEL_W-1:0] pix);
      int                idx;
      int                horiz;
      int                older;
      int                newer;
      smooth_result_type found [$];
      if (frame_col >= 2) begin
         idx = frame_col - 2;
         horiz = (int'(prev_pix[1]) + 2 * int'(prev_pix[0]) + int'(pix)) >> 2;
         older = int'(line_older[idx]);
         newer = int'(line_newer[idx]);
         if (frame_row >= 2)
            found.push_back('{PIXEL_W'((older + 2 * newer + horiz) >> 2), COORD_W'(idx),
                              COORD_W'(frame_row - 2), 1'b0});
         // The last input row also releases the two rows that only have the
         // horizontal pass.
         if (frame_row == effective_dim(cfg_height) - 1) begin
            found.push_back('{PIXEL_W'(newer), COORD_W'(idx), COORD_W'(frame_row - 1), 1'b0});
            found.push_back('{PIXEL_W'(horiz), COORD_W'(idx), COORD_W'(frame_row), 1'b0});
         end
         line_older[idx] = PIXEL_W'(newer);
         line_newer[idx] = PIXEL_W'(horiz);
      end
      prev_pix[1] = prev_pix[0];
      prev_pix[0] = pix;
      step_position(frame_col, frame_row);
      if (found.size() > 0) found[found.size() - 1].run_end = 1'b1;
      foreach (found[i]) smoothed_due.push_back(found[i]);
   endfunction

   // Idle cycles before the next transfer; runs of busy traffic and runs that have
   // no gaps at all are drawn at random.
   function automatic int draw_idle(inout int stretch_left, inout bit calm);
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(8, 48);
         calm = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   always @(posedge clock) begin
      smooth_result_type want;
      pixel_taken = !reset && req_valid && !req_stall;
      result_taken = !reset && rsp_valid && !rsp_stall;
      if (pixel_taken) predict_smoothing(req_pixel);
      if (result_taken) begin
         if (smoothed_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("Unexpected result: smoothed %0d column %0d row %0d run_end %0d",
                        rsp_smoothed, rsp_out_column, rsp_out_row, rsp_run_end);
         end else begin
            want = smoothed_due.pop_front();
            if (rsp_smoothed !== want.smoothed || rsp_out_column !== want.column ||
                rsp_out_row !== want.row || rsp_run_end !== want.run_end) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d %s",
                           want.smoothed, want.column, want.row, want.run_end,
                           rsp_smoothed, rsp_out_column, rsp_out_row, rsp_run_end,
                           "(smoothed/column/row/run_end)");
            end
         end
      end
   end

   // Pixel driver: a stalled pixel is held, otherwise the next one goes out
   // once its idle cycles have passed.
   always @(negedge clock) begin
      if (!reset) begin
         if (pixel_taken) send_wait = draw_idle(send_stretch, send_calm);
         if (!req_valid || pixel_taken) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_pixel <= pixel_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver, with one long hold-off so that the block backs up. Once
   // armed, the hold-off starts with the first result that is offered.
   always @(negedge clock) begin
      bit stall_next;
      stall_next = 1'b0;
      if (!reset) begin
         if (result_taken) recv_wait = draw_idle(recv_stretch, recv_calm);
         if (hold_armed && !hold_done && (hold_count > 0 || rsp_valid)) begin
            hold_count++;
            stall_next = 1'b1;
            if (hold_count >= LONG_HOLD) hold_done = 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            stall_next = 1'b1;
         end
      end
      rsp_stall <= stall_next;
   end

   task automatic write_register(input bsm3_pkg::csr_index_type idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == bsm3_pkg::CSR_IMAGE_WIDTH) cfg_width = value[CSR_DATA_W-1:0];
      else cfg_height = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_pixels(input int count, input fill_kind_type fill);
      logic [PIXEL_W-1:0] pix;
      for (int n = 0; n < count; n++) begin
         case (fill)
            FILL_WHITE: pix = '1;
            FILL_CHECKER: pix = n[0] ? '1 : '0;
            default: begin
               if ($urandom_range(0, 7) == 0) pix = $urandom_range(0, 1) ? '1 : '0;
               else pix = PIXEL_W'($urandom_range(0, 255));
            end
         endcase
         pixel_queue.push_back(pix);
         step_position(plan_col, plan_row);
      end
   endtask

   function automatic int pixels_to_frame_end();
      int col;
      int row;
      int count;
      col = plan_col;
      row = plan_row;
      count = 0;
      do begin
         step_position(col, row);
         count++;
      end while (col != 0 || row != 0);
      return count;
   endfunction

   // Waits until every pixel is sent and every result is in, then lets the
   // pipeline settle, since pixels near the row start produce nothing.
   task automatic wait_idle();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_valid || smoothed_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int random_pixels;
      int count;
      random_pixels = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first frame starts at the saturated maximum size and is cut to the
      // widest size used later within its first row, so that every line entry
      // read later has been written. The first result starts the long hold-off.
      hold_armed = 1'b1;
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, 4095);
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 2);
      queue_pixels(WIDEST_FRAME, FILL_RANDOM);
      wait_idle();
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, WIDEST_FRAME);
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_idle();

      // Smallest frame, with the values below the minimum.
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, 0);
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 1);
      queue_pixels(pixels_to_frame_end(), FILL_WHITE);
      queue_pixels(pixels_to_frame_end(), FILL_CHECKER);
      wait_idle();

      // Width cut in the middle of a row: the row ends after the next pixel.
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, 5);
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 4);
      queue_pixels(13, FILL_RANDOM);
      wait_idle();
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, 3);
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_idle();

      // Height cut below the current row: the frame ends with this row.
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, 4);
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 6);
      queue_pixels(17, FILL_RANDOM);
      wait_idle();
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 3);
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_idle();

      // Height above the maximum saturates; ten rows in, a smaller height
      // ends the frame with the current row.
      write_register(bsm3_pkg::CSR_IMAGE_WIDTH, 3);
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 4095);
      queue_pixels(30, FILL_RANDOM);
      wait_idle();
      write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, 3);
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_idle();

      while (random_pixels < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: ;
            1: write_register(bsm3_pkg::CSR_IMAGE_WIDTH, $urandom_range(0, 9) == 0 ?
                              $urandom_range(0, 2) : $urandom_range(3, 12));
            2: write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, $urandom_range(0, 9) == 0 ?
                              $urandom_range(0, 2) : $urandom_range(3, 8));
            default: begin
               write_register(bsm3_pkg::CSR_IMAGE_WIDTH, $urandom_range(0, 7) == 0 ?
                              $urandom_range(13, WIDEST_FRAME) : $urandom_range(3, 12));
               write_register(bsm3_pkg::CSR_IMAGE_HEIGHT, $urandom_range(3, 8));
            end
         endcase
         // Mostly whole frames; now and then a broken one, so that the next
         // size change lands in the middle of a frame.
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 2 * effective_dim(cfg_width));
         else count = pixels_to_frame_end();
         queue_pixels(count, FILL_RANDOM);
         random_pixels += count;
         wait_idle();
      end

      if (mismatch_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", smoothed_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
